// ===== rtl/berc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// berc_pkg
// Types, codes and helpers shared by the bit error rate checker modules.
// ----------------------------------------------------------------------------
package berc_pkg;

    localparam int DATA_W  = 16;
    localparam int ERRS_W  = 5;
    localparam int ACC_W   = 32;
    localparam int LEVEL_W = 9;

    localparam logic CMD_PUSH    = 1'b0;
    localparam logic CMD_COMPARE = 1'b1;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } berc_status_t;

    typedef struct packed {
        logic              command;
        logic [DATA_W-1:0] data_word;
    } berc_in_t;

    typedef struct packed {
        logic [ERRS_W-1:0]  word_bit_errors;
        logic [ACC_W-1:0]   total_bit_errors;
        logic [ACC_W-1:0]   total_bits_compared;
        logic [LEVEL_W-1:0] reference_level;
        berc_status_t       status;
    } berc_out_t;

    // One classified item on its way from the front part to the back part.
    typedef struct packed {
        logic               counted;
        logic [DATA_W-1:0]  diff;
        logic [LEVEL_W-1:0] level;
        berc_status_t       status;
    } berc_op_t;

    // Counts set bits as four nibble sums added together.
    function automatic logic [ERRS_W-1:0] ones_in(input logic [DATA_W-1:0] v);
        logic [2:0]        nib [4];
        logic [ERRS_W-1:0] sum;
        for (int n = 0; n < 4; n++)
        begin
            nib[n] = 3'(v[4*n]) + 3'(v[4*n+1]) + 3'(v[4*n+2]) + 3'(v[4*n+3]);
        end
        sum = ERRS_W'(nib[0]) + ERRS_W'(nib[1]) + ERRS_W'(nib[2]) + ERRS_W'(nib[3]);
        return sum;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/berc_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// berc_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module berc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/berc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// berc_front
// Accepts items, keeps the reference FIFO pointers and classifies each item.
// ----------------------------------------------------------------------------
module berc_front
    import berc_pkg::*;
#(
    parameter int FIFO_DEPTH = 256,
    parameter int CMP_W      = 16
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    output logic          item_stall,
    input  wire berc_in_t item,
    input  wire logic     queue_full,
    output logic          op_valid,
    output berc_op_t      op
);

    localparam int IDX_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic               s1_valid_reg, s1_valid_next;
    logic               s1_counted_reg;
    logic [CMP_W-1:0]   s1_word_reg;
    logic [LEVEL_W-1:0] s1_level_reg;
    berc_status_t       s1_status_reg;

    logic             accept;
    logic             is_push;
    logic             fifo_full;
    logic             fifo_empty;
    logic             do_write;
    logic             do_read;
    logic [CMP_W-1:0] word;
    logic [CMP_W-1:0] ref_word;
    berc_status_t     status_next;

    assign item_stall = s1_valid_reg && queue_full;
    assign accept     = item_valid && !item_stall;
    assign is_push    = (item.command == CMD_PUSH);
    assign fifo_full  = (count_reg == CNT_W'(FIFO_DEPTH));
    assign fifo_empty = (count_reg == '0);
    assign do_write   = accept && is_push && !fifo_full;
    assign do_read    = accept && !is_push && !fifo_empty;
    assign word       = item.data_word[CMP_W-1:0];

    berc_ram #(
        .WIDTH (CMP_W),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (do_write),
        .waddr (wr_idx_reg),
        .wdata (word),
        .re    (do_read),
        .raddr (rd_idx_reg),
        .rdata (ref_word)
    );

    always_comb
    begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        count_next  = count_reg;
        status_next = ST_OK;
        if (do_write)
        begin
            wr_idx_next = (wr_idx_reg == IDX_W'(FIFO_DEPTH - 1)) ? '0 : wr_idx_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
        if (do_read)
        begin
            rd_idx_next = (rd_idx_reg == IDX_W'(FIFO_DEPTH - 1)) ? '0 : rd_idx_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
        if (is_push && fifo_full)
        begin
            status_next = ST_OVERFLOW;
        end
        else if (!is_push && fifo_empty)
        begin
            status_next = ST_UNDERFLOW;
        end

        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (!queue_full)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg   <= '0;
            rd_idx_reg   <= '0;
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            wr_idx_reg   <= wr_idx_next;
            rd_idx_reg   <= rd_idx_next;
            count_reg    <= count_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_counted_reg <= do_read;
            s1_word_reg    <= word;
            s1_level_reg   <= LEVEL_W'(count_next);
            s1_status_reg  <= status_next;
        end
    end

    // The store's read data arrives together with the staged item.
    assign op_valid   = s1_valid_reg && !queue_full;
    assign op.counted = s1_counted_reg;
    assign op.diff    = s1_counted_reg ? DATA_W'(ref_word ^ s1_word_reg) : '0;
    assign op.level   = s1_level_reg;
    assign op.status  = s1_status_reg;

endmodule
`default_nettype wire

// ===== rtl/berc_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// berc_queue
// Two-entry queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module berc_queue
    import berc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire berc_op_t push_op,
    output logic          full,
    input  wire logic     pop,
    output logic          head_valid,
    output berc_op_t      head_op
);

    berc_op_t   entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_op    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/berc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// berc_back
// Counts bit errors, updates the saturating totals and holds the result beat.
// ----------------------------------------------------------------------------
module berc_back
    import berc_pkg::*;
#(
    parameter int WORD_BITS = 16
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     op_valid,
    input  wire berc_op_t op,
    output logic          op_take,
    output logic          result_valid,
    input  wire logic     result_stall,
    output berc_out_t     result
);

    localparam logic [ACC_W-1:0] BIT_INC = ACC_W'(WORD_BITS);

    logic [ACC_W-1:0] err_acc_reg, err_acc_next;
    logic [ACC_W-1:0] bit_acc_reg, bit_acc_next;
    logic             out_valid_reg, out_valid_next;
    berc_out_t        out_reg;

    logic [ERRS_W-1:0] errs;
    logic [ACC_W:0]    err_sum;
    logic [ACC_W:0]    bit_sum;

    assign op_take = op_valid && (!out_valid_reg || !result_stall);
    assign errs    = ones_in(op.diff);
    assign err_sum = {1'b0, err_acc_reg} + (ACC_W + 1)'(errs);
    assign bit_sum = {1'b0, bit_acc_reg} + {1'b0, BIT_INC};

    always_comb
    begin
        err_acc_next = err_acc_reg;
        bit_acc_next = bit_acc_reg;
        if (op.counted)
        begin
            err_acc_next = err_sum[ACC_W] ? ACC_MAX : err_sum[ACC_W-1:0];
            bit_acc_next = bit_sum[ACC_W] ? ACC_MAX : bit_sum[ACC_W-1:0];
        end

        out_valid_next = out_valid_reg;
        if (op_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_acc_reg   <= '0;
            bit_acc_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (op_take)
            begin
                err_acc_reg <= err_acc_next;
                bit_acc_reg <= bit_acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_take)
        begin
            out_reg.word_bit_errors     <= errs;
            out_reg.total_bit_errors    <= err_acc_next;
            out_reg.total_bits_compared <= bit_acc_next;
            out_reg.reference_level     <= op.level;
            out_reg.status              <= op.status;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
`default_nettype wire

// ===== rtl/bit_error_rate_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bit_error_rate_checker
// Checks received words against a FIFO of reference words and keeps
// saturating totals of bit errors and of bits compared.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                              Beat
//  -------   ----------------------------------   ------------------------------
//  item      item_valid, item_stall, item         command and data word
//  result    result_valid, result_stall, result   errors, totals, level, status
//
// One item enters per cycle while item_stall is low, and every item yields
// exactly one result beat. A result passes through the front stage, where
// the reference store is read, then the queue, and then the output register.
// The reference store has one write and one read port, which sets the rate
// at one item per cycle when nothing stalls.
// Reset clears the FIFO pointers, the fill count, both totals and all valid
// flags; the reference store itself is not cleared, since a compare only
// ever reads an entry that an earlier push wrote.
// A stall on the result side first fills the two-entry queue and only then
// stalls the item side.
//
// A push to a full FIFO is dropped and reports an overflow. A compare on an
// empty FIFO changes nothing and reports an underflow with zero errors.
// Data bits above WORD_BITS take no part in the comparison, but every good
// compare adds WORD_BITS to the bits-compared total.
//
module bit_error_rate_checker
    import berc_pkg::*;
#(
    parameter int FIFO_DEPTH = 256,
    parameter int WORD_BITS  = 16
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    output logic          item_stall,
    input  wire berc_in_t item,
    output logic          result_valid,
    input  wire logic     result_stall,
    output berc_out_t     result
);

    // Only the data word's own bits can ever differ.
    localparam int CMP_W = (WORD_BITS < DATA_W) ? WORD_BITS : DATA_W;

    logic     queue_full;
    logic     front_valid;
    berc_op_t front_op;
    logic     head_valid;
    berc_op_t head_op;
    logic     head_take;

    berc_front #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .CMP_W      (CMP_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .queue_full (queue_full),
        .op_valid   (front_valid),
        .op         (front_op)
    );

    berc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_valid),
        .push_op    (front_op),
        .full       (queue_full),
        .pop        (head_take),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    berc_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .op_valid     (head_valid),
        .op           (head_op),
        .op_take      (head_take),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
`default_nettype wire

// ===== dv/bit_error_rate_checker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_error_rate_checker_tb
// Self-checking testbench for the bit error rate checker. A scoreboard model
// keeps its own queue of reference words and its own saturating totals. It
// predicts one report per accepted beat and compares every field of each
// result beat against the oldest prediction. The sender works in bursts with
// gaps, and the receiver stalls on its own changing pattern.
// ----------------------------------------------------------------------------
module bit_error_rate_checker_tb;
    import berc_pkg::*;

    localparam int FIFO_DEPTH   = 256;
    localparam int WORD_BITS    = 16;
    localparam int RANDOM_ITEMS = 320;
    // Well over the slowest legal run: about 850 beats with random sender gaps
    // and random result stalls.
    localparam int LIMIT_CYCLES = 200000;
    // Allow the queue and the output register to drain after the last report.
    localparam int DRAIN_CYCLES = 16;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      item_valid = 1'b0;
    logic      item_stall;
    berc_in_t  item = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    berc_out_t result;

    // Scoreboard state: the reference words the block should be holding, the
    // totals it should report, and the reports still owed to us.
    logic [DATA_W-1:0] pending_refs[$];
    logic [ACC_W-1:0]  error_total = '0;
    logic [ACC_W-1:0]  bits_total = '0;
    berc_out_t         predicted_reports[$];

    int error_count = 0;
    int cycle_count = 0;
    int burst_left = 0;
    // While quiet is set, neither side inserts gaps or stalls.
    bit quiet = 1'b0;
    int stall_mode = 0;
    int stall_left = 0;

    bit_error_rate_checker #(
        .FIFO_DEPTH(FIFO_DEPTH),
        .WORD_BITS (WORD_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hard stop in case the block hangs or loses a beat.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d reports outstanding", $time,
                     predicted_reports.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Scoreboard model
    // ------------------------------------------------------------------------

    // Accumulators hold at their maximum instead of wrapping.
    function automatic logic [ACC_W-1:0] add_clamped(input logic [ACC_W-1:0] acc,
                                                     input logic [ACC_W-1:0] amount);
        logic [ACC_W:0] sum;
        sum = {1'b0, acc} + {1'b0, amount};
        return sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
    endfunction

    // Applies one accepted item to the model and returns the report that the
    // block owes for it. A push to a full FIFO and a compare on an empty one
    // leave the model untouched apart from the status.
    function automatic berc_out_t score_item(input berc_in_t beat);
        berc_out_t         report;
        logic [DATA_W-1:0] oldest;
        logic [DATA_W-1:0] mask;
        mask = (WORD_BITS >= DATA_W) ? '1 : DATA_W'((1 << WORD_BITS) - 1);
        report.word_bit_errors = '0;
        report.status = ST_OK;
        if (beat.command == CMD_PUSH)
        begin
            if (pending_refs.size() >= FIFO_DEPTH)
                report.status = ST_OVERFLOW;
            else
                pending_refs.push_back(beat.data_word & mask);
        end
        else if (pending_refs.size() == 0)
        begin
            report.status = ST_UNDERFLOW;
        end
        else
        begin
            oldest = pending_refs.pop_front();
            report.word_bit_errors = ERRS_W'($countones((oldest ^ beat.data_word) & mask));
            error_total = add_clamped(error_total, ACC_W'(report.word_bit_errors));
            bits_total = add_clamped(bits_total, ACC_W'(WORD_BITS));
        end
        report.total_bit_errors = error_total;
        report.total_bits_compared = bits_total;
        report.reference_level = LEVEL_W'(pending_refs.size());
        return report;
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Drives one beat and returns once the block has taken it. The sender
    // runs in bursts; at the start of each burst it may idle for a few cycles.
    // Valid stays high from one beat to the next inside a burst, so it never
    // gets two assignments in the same step.
    task automatic send_item(input logic cmd, input logic [DATA_W-1:0] word);
        berc_in_t beat;
        int       gap;
        beat.command = cmd;
        beat.data_word = word;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_valid <= 1'b1;
        item <= beat;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predicted_reports.push_back(score_item(beat));
    endtask

    // A reference word for a push, with the all-zero and all-one words
    // showing up often.
    function automatic logic [DATA_W-1:0] pick_reference();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // A received word for a compare: mostly the oldest reference with a few
    // flipped bits, sometimes clean, inverted, or unrelated noise.
    function automatic logic [DATA_W-1:0] pick_received();
        logic [DATA_W-1:0] word;
        word = (pending_refs.size() != 0) ? pending_refs[0] : DATA_W'($urandom);
        case ($urandom_range(0, 7))
            0, 1:    ;
            2, 3, 4: repeat ($urandom_range(1, 3)) word[$urandom_range(0, DATA_W-1)] ^= 1'b1;
            5:       word = ~word;
            default: word = DATA_W'($urandom);
        endcase
        return word;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------------

    task automatic check_field(input string name, input logic [ACC_W-1:0] want,
                               input logic [ACC_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Each result beat taken at this edge is checked against the oldest
    // prediction. The stall for the next edge then follows a mode that is
    // picked afresh at random intervals: none, sparse, heavy, or periodic.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (predicted_reports.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, result);
                    error_count++;
                end
                else
                begin
                    check_field("word_bit_errors", ACC_W'(predicted_reports[0].word_bit_errors),
                                ACC_W'(result.word_bit_errors));
                    check_field("total_bit_errors", predicted_reports[0].total_bit_errors,
                                result.total_bit_errors);
                    check_field("total_bits_compared", predicted_reports[0].total_bits_compared,
                                result.total_bits_compared);
                    check_field("reference_level", ACC_W'(predicted_reports[0].reference_level),
                                ACC_W'(result.reference_level));
                    check_field("status", ACC_W'(predicted_reports[0].status),
                                ACC_W'(result.status));
                    void'(predicted_reports.pop_front());
                end
            end

            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(16, 80);
            end
            stall_left--;
            if (quiet)
                result_stall <= 1'b0;
            else
                case (stall_mode)
                    0:       result_stall <= 1'b0;
                    1:       result_stall <= ($urandom_range(0, 7) == 0);
                    2:       result_stall <= ($urandom_range(0, 1) == 0);
                    default: result_stall <= ((stall_left % 13) < 5);
                endcase
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hand-picked beats: compares on an empty FIFO, the all-zero and all-one
    // words, a full sixteen-bit mismatch, clean matches and a single-bit error.
    task automatic test_basic_items();
        quiet = 1'b1;
        send_item(CMD_COMPARE, 16'hFFFF);
        send_item(CMD_PUSH, 16'h0000);
        send_item(CMD_PUSH, 16'hFFFF);
        send_item(CMD_PUSH, 16'hA5A5);
        send_item(CMD_PUSH, 16'h0001);
        quiet = 1'b0;
        send_item(CMD_COMPARE, 16'hFFFF);
        send_item(CMD_COMPARE, 16'hFFFF);
        send_item(CMD_COMPARE, 16'h5A5A);
        send_item(CMD_COMPARE, 16'h0001);
        send_item(CMD_COMPARE, 16'h0000);
        send_item(CMD_PUSH, 16'h8000);
        send_item(CMD_COMPARE, 16'h0000);
        send_item(CMD_PUSH, 16'h7FFE);
        send_item(CMD_COMPARE, 16'h7FFE);
    endtask

    // Fills the FIFO to the brim so that the write index wraps, pushes a few
    // words that must be dropped, then drains it and compares past empty.
    task automatic test_full_fifo();
        quiet = 1'b1;
        repeat (FIFO_DEPTH) send_item(CMD_PUSH, pick_reference());
        quiet = 1'b0;
        repeat (3) send_item(CMD_PUSH, pick_reference());
        repeat (FIFO_DEPTH) send_item(CMD_COMPARE, pick_received());
        repeat (2) send_item(CMD_COMPARE, pick_received());
    endtask

    // Mixed traffic whose push rate leans on the FIFO level so that it
    // wanders over the whole range, with occasional long push runs that run
    // into a full FIFO and compares that land on an empty one.
    task automatic test_random_traffic();
        int push_run;
        int push_pct;
        int level;
        push_run = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            level = pending_refs.size();
            if (push_run > 0)
            begin
                push_run--;
                send_item(CMD_PUSH, pick_reference());
            end
            else
            begin
                if ($urandom_range(0, 31) == 0)
                    push_run = $urandom_range(20, 60);
                push_pct = (level < 8) ? 70 : (level > 240) ? 30 : 50;
                if ($urandom_range(0, 99) < push_pct)
                    send_item(CMD_PUSH, pick_reference());
                else
                    send_item(CMD_COMPARE, pick_received());
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_items();
        test_full_fifo();
        test_random_traffic();

        item_valid <= 1'b0;
        while (predicted_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/berc_pkg.sv
rtl/berc_ram.sv
rtl/berc_front.sv
rtl/berc_queue.sv
rtl/berc_back.sv
rtl/bit_error_rate_checker.sv
dv/bit_error_rate_checker_tb.sv
